// File: hw/rtl/rsag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsag_pkg
// Shared widths, register codes and payload types of the rotate source
// address generator.
// ----------------------------------------------------------------------------
package rsag_pkg;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int COEF_W     = 16;
  localparam int STRIDE_W   = 14;
  localparam int ADDR_W     = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ROT_STAGES = 4;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 14;
  localparam int BPP_DEF       = 3;

  localparam logic signed [COEF_W-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RST    = 16'sd0;
  localparam logic        [DIM_W-1:0]  DIM_RST    = 13'd4096;
  localparam logic        [STRIDE_W-1:0] STRIDE_RST = 14'd12288;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_THETA     = 3'd0,
    CFG_SIN_THETA     = 3'd1,
    CFG_DEST_WIDTH    = 3'd2,
    CFG_DEST_HEIGHT   = 3'd3,
    CFG_SOURCE_WIDTH  = 3'd4,
    CFG_SOURCE_HEIGHT = 3'd5,
    CFG_SOURCE_STRIDE = 3'd6,
    CFG_DEST_STRIDE   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_theta;
    logic signed [COEF_W-1:0] sin_theta;
    logic [DIM_W-1:0]         dest_width;
    logic [DIM_W-1:0]         dest_height;
    logic [DIM_W-1:0]         source_width;
    logic [DIM_W-1:0]         source_height;
    logic [STRIDE_W-1:0]      source_stride;
    logic [STRIDE_W-1:0]      dest_stride;
  } cfg_regs_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } in_word_t;

  typedef struct packed {
    logic               inside_res;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
  } out_word_t;

  typedef struct packed {
    logic [ROT_STAGES-1:0] stage_en;
    logic                  out_en;
  } pipe_en_t;

endpackage

// File: hw/rtl/rsag_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsag_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rsag_cfg import rsag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             cfg_o
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_COS_THETA:     regs_nxt.cos_theta     = signed'(cfg_wdata);
        CFG_SIN_THETA:     regs_nxt.sin_theta     = signed'(cfg_wdata);
        CFG_DEST_WIDTH:    regs_nxt.dest_width    = cfg_wdata[DIM_W-1:0];
        CFG_DEST_HEIGHT:   regs_nxt.dest_height   = cfg_wdata[DIM_W-1:0];
        CFG_SOURCE_WIDTH:  regs_nxt.source_width  = cfg_wdata[DIM_W-1:0];
        CFG_SOURCE_HEIGHT: regs_nxt.source_height = cfg_wdata[DIM_W-1:0];
        CFG_SOURCE_STRIDE: regs_nxt.source_stride = cfg_wdata[STRIDE_W-1:0];
        CFG_DEST_STRIDE:   regs_nxt.dest_stride   = cfg_wdata[STRIDE_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.cos_theta     <= COS_RST;
      regs_r.sin_theta     <= SIN_RST;
      regs_r.dest_width    <= DIM_RST;
      regs_r.dest_height   <= DIM_RST;
      regs_r.source_width  <= DIM_RST;
      regs_r.source_height <= DIM_RST;
      regs_r.source_stride <= STRIDE_RST;
      regs_r.dest_stride   <= STRIDE_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_o = regs_r;

endmodule

// File: hw/rtl/rsag_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsag_rotate
// Four-stage coordinate pipeline: centre offsets, coefficient products,
// fixed-point sums, then truncation toward zero and the bound check.
// ----------------------------------------------------------------------------
module rsag_rotate import rsag_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic [ROT_STAGES-1:0] stage_en,
  input  cfg_regs_t             cfg,
  input  in_word_t              in_data,
  output logic                  inside_o,
  output logic [COORD_W-1:0]    ux_o,
  output logic [COORD_W-1:0]    uy_o
);

  localparam int DX_W   = COORD_W + 1;
  localparam int PROD_W = DX_W + COEF_W;
  localparam int OFF_W  = COORD_W + FRAC_BITS + 1;
  localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;
  localparam int TR_W   = SUM_W - FRAC_BITS;
  localparam int CMP_W  = ((TR_W > DIM_W) ? TR_W : DIM_W) + 1;
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
    return (32'(dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim;
  endfunction

  logic [DIM_W-1:0] dw, dh, sw, sh;

  assign dw = clamp_dim(cfg.dest_width);
  assign dh = clamp_dim(cfg.dest_height);
  assign sw = clamp_dim(cfg.source_width);
  assign sh = clamp_dim(cfg.source_height);

  logic signed [DX_W-1:0]   dx_r, dy_r;
  logic signed [PROD_W-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [SUM_W-1:0]  sx_r, sy_r;
  logic signed [OFF_W-1:0]  ox, oy;
  logic signed [SUM_W-1:0]  sx_nxt, sy_nxt;
  logic signed [SUM_W-1:0]  bx, by;
  logic [TR_W-1:0]          tx, ty;
  logic                     in_x, in_y;
  logic                     inside_r;
  logic [COORD_W-1:0]       ux_r, uy_r;

  assign ox = {1'b0, sw[DIM_W-1:1], {FRAC_BITS{1'b0}}};
  assign oy = {1'b0, sh[DIM_W-1:1], {FRAC_BITS{1'b0}}};

  assign sx_nxt = SUM_W'(p_xc_r) - SUM_W'(p_ys_r) + SUM_W'(ox);
  assign sy_nxt = SUM_W'(p_xs_r) + SUM_W'(p_yc_r) + SUM_W'(oy);

  assign bx = sx_r + (sx_r[SUM_W-1] ? BIAS : '0);
  assign by = sy_r + (sy_r[SUM_W-1] ? BIAS : '0);
  assign tx = bx[SUM_W-1:FRAC_BITS];
  assign ty = by[SUM_W-1:FRAC_BITS];

  assign in_x = !tx[TR_W-1] && (CMP_W'(tx) < CMP_W'(sw));
  assign in_y = !ty[TR_W-1] && (CMP_W'(ty) < CMP_W'(sh));

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dx_r <= signed'({1'b0, in_data.dest_x}) - signed'({1'b0, dw[DIM_W-1:1]});
      dy_r <= signed'({1'b0, in_data.dest_y}) - signed'({1'b0, dh[DIM_W-1:1]});
    end
    if (stage_en[1]) begin
      p_xc_r <= dx_r * cfg.cos_theta;
      p_ys_r <= dy_r * cfg.sin_theta;
      p_xs_r <= dx_r * cfg.sin_theta;
      p_yc_r <= dy_r * cfg.cos_theta;
    end
    if (stage_en[2]) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (stage_en[3]) begin
      inside_r <= in_x && in_y;
      ux_r     <= (in_x && in_y) ? tx[COORD_W-1:0] : '0;
      uy_r     <= (in_x && in_y) ? ty[COORD_W-1:0] : '0;
    end
  end

  assign inside_o = inside_r;
  assign ux_o     = ux_r;
  assign uy_o     = uy_r;

endmodule

// File: hw/rtl/rsag_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsag_addr
// Byte address pipeline and output word register.
// ----------------------------------------------------------------------------
module rsag_addr import rsag_pkg::*; #(
  parameter int BYTES_PER_PIXEL = BPP_DEF
) (
  input  logic               clk,
  input  pipe_en_t           pen,
  input  cfg_regs_t          cfg,
  input  in_word_t           in_data,
  input  logic               inside_i,
  input  logic [COORD_W-1:0] ux_i,
  input  logic [COORD_W-1:0] uy_i,
  output out_word_t          out_data
);

  localparam logic [ADDR_W-1:0] BPP = ADDR_W'(BYTES_PER_PIXEL);

  logic [COORD_W-1:0] x_r;
  logic [ADDR_W-1:0]  drow_r;
  logic [ADDR_W-1:0]  daddr_b_r, daddr_c_r, daddr_d_r;
  logic [ADDR_W-1:0]  saddr_nxt;
  out_word_t          out_r;

  assign saddr_nxt = ADDR_W'(uy_i) * ADDR_W'(cfg.source_stride) + ADDR_W'(ux_i) * BPP;

  always_ff @(posedge clk) begin
    if (pen.stage_en[0]) begin
      x_r    <= in_data.dest_x;
      drow_r <= ADDR_W'(in_data.dest_y) * ADDR_W'(cfg.dest_stride);
    end
    if (pen.stage_en[1]) begin
      daddr_b_r <= drow_r + ADDR_W'(x_r) * BPP;
    end
    if (pen.stage_en[2]) begin
      daddr_c_r <= daddr_b_r;
    end
    if (pen.stage_en[3]) begin
      daddr_d_r <= daddr_c_r;
    end
    if (pen.out_en) begin
      out_r.inside_res <= inside_i;
      out_r.src_x      <= ux_i;
      out_r.src_y      <= uy_i;
      out_r.src_addr   <= inside_i ? saddr_nxt : '0;
      out_r.dst_addr   <= daddr_d_r;
    end
  end

  assign out_data = out_r;

endmodule

// File: hw/rtl/rotate_source_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_source_address_gen
// Nearest-neighbor inverse-rotation address generator for a pixel stream.
//
// Each input word carries one destination pixel coordinate. The matching
// output word gives the inside flag, the source coordinate, the source byte
// address and the destination byte address. Both channels use valid and
// stall; a word moves at a clock edge with valid high and stall low.
// The user must write sine, cosine, image sizes and strides through the cfg_
// port only while no word is in flight; the block does not enforce this.
// The pipeline has five register stages: centre offsets, coefficient
// products, fixed-point sums, the bound check and the output word
// register. One word is taken every cycle unless a receiver stall has
// filled every stage.
// Reset clears all valid bits and loads the default registers (angle zero,
// 4096 by 4096 images, stride 12288). When the receiver stalls, the output
// word holds and each stage moves on only into a free slot, so input is
// still taken until every stage is full.
// ----------------------------------------------------------------------------
module rotate_source_address_gen import rsag_pkg::*; #(
  parameter int MAX_DIM         = MAX_DIM_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int BYTES_PER_PIXEL = BPP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t             cfg;
  pipe_en_t              pen;
  logic [ROT_STAGES-1:0] v_r;
  logic [ROT_STAGES-1:0] v_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  src_hit;
  logic [COORD_W-1:0]    ux, uy;

  always_comb begin
    pen.out_en = !out_valid_r || !out_stall;
    pen.stage_en[ROT_STAGES-1] = !v_r[ROT_STAGES-1] || pen.out_en;
    for (int k = ROT_STAGES - 2; k >= 0; k--) begin
      pen.stage_en[k] = !v_r[k] || pen.stage_en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (pen.stage_en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < ROT_STAGES; k++) begin
      if (pen.stage_en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
    out_valid_nxt = pen.out_en ? v_r[ROT_STAGES-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !pen.stage_en[0];
  assign out_valid = out_valid_r;

  rsag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  rsag_rotate #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .clk      (clk),
    .stage_en (pen.stage_en),
    .cfg      (cfg),
    .in_data  (in_data),
    .inside_o (src_hit),
    .ux_o     (ux),
    .uy_o     (uy)
  );

  rsag_addr #(
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_addr (
    .clk      (clk),
    .pen      (pen),
    .cfg      (cfg),
    .in_data  (in_data),
    .inside_i (src_hit),
    .ux_i     (ux),
    .uy_i     (uy),
    .out_data (out_data)
  );

endmodule

// File: test/rotate_source_address_gen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_source_address_gen_tb
// Self-checking testbench for the rotate source address generator.
//
// Destination coordinates are streamed in bursts while the receiver stalls
// on a changing pattern. A scoreboard maps each accepted coordinate back
// through the programmed rotation and compares every result word, field by
// field, in order. The register set is reprogrammed between phases, covering
// the reset defaults, quarter and half turns, oversize and zero image sizes,
// coefficients beyond plus or minus one and random settings.
// ----------------------------------------------------------------------------
module rotate_source_address_gen_tb import rsag_pkg::*; ();

  localparam int NUM_PHASES     = 12;
  localparam int RAND_PER_PHASE = 54;
  localparam int QUIET_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int IN_W           = $bits(in_word_t);

  class rotation_checker;
    longint    cos_c, sin_c, dst_w, dst_h, src_w, src_h, src_pitch, dst_pitch;
    out_word_t pending_q[$];
    int        errors, words, hits;

    function new();
      cos_c     = COS_RST;
      sin_c     = SIN_RST;
      dst_w     = DIM_RST;
      dst_h     = DIM_RST;
      src_w     = DIM_RST;
      src_h     = DIM_RST;
      src_pitch = STRIDE_RST;
      dst_pitch = STRIDE_RST;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      logic signed [COEF_W-1:0] c;
      c = v;
      case (idx)
        CFG_COS_THETA:     cos_c = c;
        CFG_SIN_THETA:     sin_c = c;
        CFG_DEST_WIDTH:    dst_w = v[DIM_W-1:0];
        CFG_DEST_HEIGHT:   dst_h = v[DIM_W-1:0];
        CFG_SOURCE_WIDTH:  src_w = v[DIM_W-1:0];
        CFG_SOURCE_HEIGHT: src_h = v[DIM_W-1:0];
        CFG_SOURCE_STRIDE: src_pitch = v[STRIDE_W-1:0];
        CFG_DEST_STRIDE:   dst_pitch = v[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint d);
      return (d > MAX_DIM_DEF) ? longint'(MAX_DIM_DEF) : d;
    endfunction

    function out_word_t map_pixel(in_word_t w);
      longint    dw, dh, sw, sh, dx, dy, fx, fy, sx, sy, sa, da;
      logic      hit;
      out_word_t r;
      dw = clamp(dst_w);
      dh = clamp(dst_h);
      sw = clamp(src_w);
      sh = clamp(src_h);
      dx = longint'(w.dest_x) - (dw >> 1);
      dy = longint'(w.dest_y) - (dh >> 1);
      fx = dx * cos_c - dy * sin_c + ((sw >> 1) << FRAC_BITS_DEF);
      fy = dx * sin_c + dy * cos_c + ((sh >> 1) << FRAC_BITS_DEF);
      // Signed division truncates toward zero.
      sx = fx / (longint'(1) << FRAC_BITS_DEF);
      sy = fy / (longint'(1) << FRAC_BITS_DEF);
      hit = (sx >= 0) && (sx < sw) && (sy >= 0) && (sy < sh);
      r = '0;
      if (hit) begin
        sa = sy * src_pitch + sx * BPP_DEF;
        r.inside_res = 1'b1;
        r.src_x      = sx[COORD_W-1:0];
        r.src_y      = sy[COORD_W-1:0];
        r.src_addr   = sa[ADDR_W-1:0];
      end
      da = longint'(w.dest_y) * dst_pitch + longint'(w.dest_x) * BPP_DEF;
      r.dst_addr = da[ADDR_W-1:0];
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_q.push_back(map_pixel(w));
    endfunction

    function void flag(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: result word %h arrived with nothing pending", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      words++;
      if (want.inside_res) hits++;
      if (got.inside_res !== want.inside_res)
        flag("inside_res", ADDR_W'(want.inside_res), ADDR_W'(got.inside_res));
      if (got.src_x !== want.src_x)
        flag("src_x", ADDR_W'(want.src_x), ADDR_W'(got.src_x));
      if (got.src_y !== want.src_y)
        flag("src_y", ADDR_W'(want.src_y), ADDR_W'(got.src_y));
      if (got.src_addr !== want.src_addr) flag("src_addr", want.src_addr, got.src_addr);
      if (got.dst_addr !== want.dst_addr) flag("dst_addr", want.dst_addr, got.dst_addr);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rotation_checker chk;
  int              quiet_cycles = 0;
  int              stall_mode   = 0;
  int              stall_left   = 0;
  int unsigned     stall_tick   = 0;

  // Cosine and sine pairs for a set of first-quadrant angles.
  int angle_c [6] = '{16384, 14189, 11585, 8192, 4240, 0};
  int angle_s [6] = '{0, 8192, 11585, 14189, 15826, 16384};

  rotate_source_address_gen dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver switches between free flow, light, heavy and periodic stalls.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) chk.note_input(in_data);
      if (out_valid && !out_stall) chk.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_xy(input int x, input int y);
    in_word_t w;
    w.dest_x = COORD_W'(x);
    w.dest_y = COORD_W'(y);
    send_word(w);
  endtask

  task automatic pause(input int n, input bit drain);
    in_valid <= 1'b0;
    if (drain) begin
      while (chk.pending_q.size() != 0) @(negedge clk);
    end
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    chk.write_reg(idx, v);
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'($urandom_range(4097, 8191));
    if (r < 6) return CFG_DATA_W'($urandom_range(1, 4096));
    return CFG_DATA_W'($urandom_range(1, 640));
  endfunction

  function automatic int pick_burst();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(32, 64) : $urandom_range(1, 12);
  endfunction

  task automatic load_settings(input int p);
    logic [CFG_DATA_W-1:0] co, si, dw, dh, sw, sh, ss, ds;
    int                    k;
    case (p)
      1: begin
        co = -16'sd16384; si = 0;
        dw = 640; dh = 480; sw = 640; sh = 480; ss = 1920; ds = 1920;
      end
      2: begin
        co = 0; si = 16384;
        dw = 480; dh = 640; sw = 640; sh = 480; ss = 1920; ds = 1440;
      end
      3: begin
        co = 16'h7fff; si = 16'h8000;
        dw = 8191; dh = 8191; sw = 8191; sh = 8191; ss = 16383; ds = 16383;
      end
      4: begin
        co = 11585; si = 11585;
        dw = 0; dh = 0; sw = 0; sh = 0; ss = 0; ds = 0;
      end
      5: begin
        co = -16'sd11585; si = 11585;
        dw = 1; dh = 1; sw = 1; sh = 1; ss = 3; ds = 3;
      end
      6: begin
        co = 14189; si = -16'sd8192;
        dw = 4096; dh = 4096; sw = 4096; sh = 4096; ss = 16383; ds = 0;
      end
      default: begin
        k  = $urandom_range(0, 5);
        co = CFG_DATA_W'(angle_c[k]);
        si = CFG_DATA_W'(angle_s[k]);
        if ($urandom_range(0, 1)) co = -co;
        if ($urandom_range(0, 1)) si = -si;
        if ($urandom_range(0, 3) == 0) begin
          co = CFG_DATA_W'($urandom);
          si = CFG_DATA_W'($urandom);
        end
        dw = pick_dim();
        dh = pick_dim();
        sw = pick_dim();
        sh = pick_dim();
        ss = CFG_DATA_W'($urandom_range(0, 16383));
        ds = CFG_DATA_W'($urandom_range(0, 16383));
      end
    endcase
    write_reg(CFG_COS_THETA, co);
    write_reg(CFG_SIN_THETA, si);
    write_reg(CFG_DEST_WIDTH, dw);
    write_reg(CFG_DEST_HEIGHT, dh);
    write_reg(CFG_SOURCE_WIDTH, sw);
    write_reg(CFG_SOURCE_HEIGHT, sh);
    write_reg(CFG_SOURCE_STRIDE, ss);
    write_reg(CFG_DEST_STRIDE, ds);
    cfg_we <= 1'b0;
  endtask

  task automatic random_words(input int count);
    int       burst;
    longint   lim_x, lim_y;
    in_word_t w;
    burst = pick_burst();
    lim_x = chk.clamp(chk.dst_w);
    lim_y = chk.clamp(chk.dst_h);
    if (lim_x == 0) lim_x = MAX_DIM_DEF;
    if (lim_y == 0) lim_y = MAX_DIM_DEF;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        w.dest_x = COORD_W'($urandom_range(0, int'(lim_x) - 1));
        w.dest_y = COORD_W'($urandom_range(0, int'(lim_y) - 1));
      end else begin
        w = IN_W'($urandom);
      end
      send_word(w);
      burst = burst - 1;
      if (burst == 0) begin
        pause($urandom_range(1, 8), $urandom_range(0, 15) == 0);
        burst = pick_burst();
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_COS_THETA;
    cfg_wdata    = '0;
    chk          = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        pause(1, 1'b1);
        load_settings(p);
      end
      if (p <= 6 && p != 4) begin
        send_xy(0, 0);
        send_xy(4095, 4095);
        send_xy(0, 4095);
        send_xy(4095, 0);
      end
      if (p == 0) send_xy(2048, 2048);
      random_words(RAND_PER_PHASE);
    end
    pause(1, 1'b1);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d result words over %0d register settings.", chk.words, NUM_PHASES);
    $display("%0d mapped inside the source image, %0d fell outside.",
             chk.hits, chk.words - chk.hits);
    if (chk.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
